// ===== rtl/asu_pkg.sv =====
// Package for the AEGIS-128X4 state update block: item kinds, queue entry type,
// the AES S-box and the AES round function. No dependencies.
package asu_pkg;

    localparam int LANES = 4;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic         lane_ok;
        logic [1:0]   lane;
        logic [2:0]   blk;
        logic         half;
        logic [63:0]  wval;
        logic [127:0] msg1;
        logic [127:0] msg2;
    } cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES encryption round; byte k sits in bits 8k+7:8k.
    function automatic logic [127:0] aes_round(input logic [127:0] blk,
                                               input logic [127:0] key);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] res;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = sbox(blk[8*(4*((c+r)%4)+r) +: 8]);
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            res[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1) ^ key[8*(4*c)   +: 8];
            res[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2) ^ key[8*(4*c+1) +: 8];
            res[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3) ^ key[8*(4*c+2) +: 8];
            res[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0) ^ key[8*(4*c+3) +: 8];
        end
        return res;
    endfunction

endpackage

// ===== rtl/asu_front.sv =====
// Front part: takes input items, classifies them and queues them.
// Depends on asu_pkg.
module asu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_kind,
    input  logic [1:0]    s_lane,
    input  logic [2:0]    s_block_index,
    input  logic          s_half,
    input  logic [63:0]   s_write_value,
    input  logic [63:0]   s_msg1_low,
    input  logic [63:0]   s_msg1_high,
    input  logic [63:0]   s_msg2_low,
    input  logic [63:0]   s_msg2_high,
    output logic          q_valid,
    input  logic          q_ready,
    output asu_pkg::cmd_t q_cmd
);
    import asu_pkg::*;

    cmd_t       mem_reg [QDEPTH];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb begin
        in_cmd.kind    = kind_t'(s_kind);
        in_cmd.lane_ok = ({1'b0, s_lane} < 3'(LANES));
        in_cmd.lane    = s_lane;
        in_cmd.blk     = s_block_index;
        in_cmd.half    = s_half;
        in_cmd.wval    = s_write_value;
        in_cmd.msg1    = {s_msg1_high, s_msg1_low};
        in_cmd.msg2    = {s_msg2_high, s_msg2_low};
    end

    assign s_ready = (cnt_reg != 2'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = mem_reg[rptr_reg];

    assign wptr_next = push ? ~wptr_reg : wptr_reg;
    assign rptr_next = pop ? ~rptr_reg : rptr_reg;
    assign cnt_next  = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_cmd;
        end
    end
endmodule

// ===== rtl/asu_back.sv =====
// Back part: holds the lane states, performs updates, writes and reads.
// Depends on asu_pkg.
module asu_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  asu_pkg::cmd_t q_cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [63:0]   m_read_data
);
    import asu_pkg::*;

    logic [127:0] st_reg [LANES][8];
    logic [127:0] st_next [LANES][8];
    logic [127:0] upd [8];
    logic         ov_reg, ov_next;
    logic [63:0]  od_reg, od_next;
    logic         take;
    logic [127:0] sel;

    // Output register is free or drains this cycle.
    assign q_ready = !ov_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign m_valid = ov_reg;
    assign m_read_data = od_reg;

    always_comb begin
        for (int b = 0; b < 8; b++)
            upd[b] = aes_round(st_reg[q_cmd.lane][(b+7)%8], st_reg[q_cmd.lane][b]);
        upd[0] = upd[0] ^ q_cmd.msg1;
        upd[4] = upd[4] ^ q_cmd.msg2;
    end

    always_comb begin
        st_next = st_reg;
        if (take && q_cmd.lane_ok) begin
            case (q_cmd.kind)
                KIND_UPDATE: begin
                    for (int b = 0; b < 8; b++) st_next[q_cmd.lane][b] = upd[b];
                end
                KIND_WRITE: begin
                    if (q_cmd.half)
                        st_next[q_cmd.lane][q_cmd.blk][127:64] = q_cmd.wval;
                    else
                        st_next[q_cmd.lane][q_cmd.blk][63:0] = q_cmd.wval;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        sel     = st_reg[q_cmd.lane][q_cmd.blk];
        ov_next = ov_reg && !m_ready;
        od_next = od_reg;
        if (take && q_cmd.kind == KIND_READ) begin
            ov_next = 1'b1;
            od_next = !q_cmd.lane_ok ? 64'd0 : (q_cmd.half ? sel[127:64] : sel[63:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            for (int l = 0; l < LANES; l++)
                for (int b = 0; b < 8; b++) st_reg[l][b] <= '0;
        end else begin
            ov_reg  <= ov_next;
            st_reg  <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        od_reg <= od_next;
    end
endmodule

// ===== rtl/aegis_state_update_top.sv =====
// AEGIS-128X4 state store and update: throughput one item per cycle, except while a
// read result waits on a stalled result channel. An item is written into a two-entry queue
// when accepted, and the back part executes it once it is at the queue head and the back
// part is ready; a read result is held in a registered output. Each update runs eight AES rounds in parallel.
// Reset (synchronous, active low) clears all lane states to zero and empties the queue.
module aegis_state_update_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [1:0]  s_lane,
    input  logic [2:0]  s_block_index,
    input  logic        s_half,
    input  logic [63:0] s_write_value,
    input  logic [63:0] s_msg1_low,
    input  logic [63:0] s_msg1_high,
    input  logic [63:0] s_msg2_low,
    input  logic [63:0] s_msg2_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_read_data
);
    import asu_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;

    // The front queues classified items; it decouples the input from
    // stalls on the result side.
    asu_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_lane, .s_block_index,
        .s_half, .s_write_value, .s_msg1_low, .s_msg1_high, .s_msg2_low,
        .s_msg2_high, .q_valid, .q_ready, .q_cmd
    );

    // The back executes one queued item per cycle unless a read result waits.
    asu_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd, .m_valid, .m_ready, .m_read_data
    );

    // A waiting result stays until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("result dropped while stalled");

    // Back part only stalls while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_ready |-> m_valid && !m_ready)
        else $error("back part stalled without cause");

    // Input is refused only when the queue holds items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("input refused with empty queue");
endmodule

// ===== tb/aegis_state_update_checker.sv =====
// Checker for the AEGIS-128X4 state update block: watches both channels, keeps its
// own copy of the lane states, predicts read data and compares. Depends on asu_pkg.
module aegis_state_update_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [1:0]  s_lane,
    input  logic [2:0]  s_block_index,
    input  logic        s_half,
    input  logic [63:0] s_write_value,
    input  logic [63:0] s_msg1_low,
    input  logic [63:0] s_msg1_high,
    input  logic [63:0] s_msg2_low,
    input  logic [63:0] s_msg2_high,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_read_data,
    output int          fail_count,
    output int          pending_reads
);
    timeunit 1ns;
    timeprecision 1ps;
    import asu_pkg::*;

    localparam logic [7:0] SBOX_TBL [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    logic [127:0] lane_blocks [LANES][8];
    logic [63:0]  read_queue [$];

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] cipher_round(input logic [127:0] din,
                                                  input logic [127:0] rkey);
        logic [7:0] sh [16];
        logic [7:0] b0, b1, b2, b3, sum;
        logic [127:0] dout;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sh[4*c+r] = SBOX_TBL[din[8*(4*((c+r)%4)+r) +: 8]];
        for (int c = 0; c < 4; c++) begin
            b0 = sh[4*c]; b1 = sh[4*c+1]; b2 = sh[4*c+2]; b3 = sh[4*c+3];
            sum = b0 ^ b1 ^ b2 ^ b3;
            dout[32*c    +: 8] = b0 ^ sum ^ gf_double(b0 ^ b1) ^ rkey[32*c    +: 8];
            dout[32*c+8  +: 8] = b1 ^ sum ^ gf_double(b1 ^ b2) ^ rkey[32*c+8  +: 8];
            dout[32*c+16 +: 8] = b2 ^ sum ^ gf_double(b2 ^ b3) ^ rkey[32*c+16 +: 8];
            dout[32*c+24 +: 8] = b3 ^ sum ^ gf_double(b3 ^ b0) ^ rkey[32*c+24 +: 8];
        end
        return dout;
    endfunction

    assign pending_reads = read_queue.size();

    always @(posedge aclk) begin
        logic [127:0] old_blk [8];
        logic [127:0] blk;
        if (!aresetn) begin
            for (int l = 0; l < LANES; l++)
                for (int b = 0; b < 8; b++)
                    lane_blocks[l][b] = '0;
            read_queue.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                case (kind_t'(s_kind))
                    KIND_UPDATE: if (s_lane < LANES) begin
                        for (int b = 0; b < 8; b++)
                            old_blk[b] = lane_blocks[s_lane][b];
                        for (int b = 0; b < 8; b++)
                            lane_blocks[s_lane][b] = cipher_round(old_blk[(b+7)%8], old_blk[b]);
                        lane_blocks[s_lane][0] ^= {s_msg1_high, s_msg1_low};
                        lane_blocks[s_lane][4] ^= {s_msg2_high, s_msg2_low};
                    end
                    KIND_WRITE: if (s_lane < LANES) begin
                        blk = lane_blocks[s_lane][s_block_index];
                        if (s_half) blk[127:64] = s_write_value;
                        else blk[63:0] = s_write_value;
                        lane_blocks[s_lane][s_block_index] = blk;
                    end
                    KIND_READ: begin
                        if (s_lane < LANES) begin
                            blk = lane_blocks[s_lane][s_block_index];
                            read_queue.push_back(s_half ? blk[127:64] : blk[63:0]);
                        end else begin
                            read_queue.push_back(64'd0);
                        end
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (read_queue.size() == 0) begin
                    $display("%0t: unexpected read item, expected none, actual %h",
                             $time, m_read_data);
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_read_data !== read_queue[0]) begin
                        $display("%0t: read_data mismatch, expected %h, actual %h",
                                 $time, read_queue[0], m_read_data);
                        fail_count <= fail_count + 1;
                    end
                    void'(read_queue.pop_front());
                end
            end
        end
    end
endmodule

// ===== tb/aegis_state_update_top_tb.sv =====
// Testbench top for the AEGIS-128X4 state update block: drives items with random
// gaps, stalls the result channel and gives the verdict. Depends on asu_pkg and the checker.
module aegis_state_update_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asu_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [1:0]  s_lane = '0;
    logic [2:0]  s_block_index = '0;
    logic        s_half = 1'b0;
    logic [63:0] s_write_value = '0;
    logic [63:0] s_msg1_low = '0;
    logic [63:0] s_msg1_high = '0;
    logic [63:0] s_msg2_low = '0;
    logic [63:0] s_msg2_high = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_read_data;
    int          fail_count;
    int          pending_reads;
    bit          stall_free = 1'b0;

    // 2 ns clock period.
    always #1 aclk = ~aclk;

    aegis_state_update_top u_dut (.*);

    aegis_state_update_checker u_checker (.*);

    // Random gap length: mostly short, now and then long.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Result side: random back-pressure, with stall-free stretches.
    initial begin
        int wait_cycles;
        forever begin
            @(posedge aclk);
            if (stall_free) begin
                m_ready <= 1'b1;
            end else begin
                wait_cycles = gap_len();
                if (wait_cycles == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (wait_cycles - 1) @(posedge aclk);
                end
            end
        end
    end

    // Presents one item and holds it until accepted. Caller is at a clock edge.
    task automatic send_item(input logic [1:0] kind, input logic [1:0] lane,
                             input logic [2:0] blk, input logic hf,
                             input logic [63:0] wval, input logic [63:0] m1l,
                             input logic [63:0] m1h, input logic [63:0] m2l,
                             input logic [63:0] m2h, input bit gaps);
        int idle;
        idle = gaps ? gap_len() : 0;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_lane <= lane;
        s_block_index <= blk;
        s_half <= hf;
        s_write_value <= wval;
        s_msg1_low <= m1l;
        s_msg1_high <= m1h;
        s_msg2_low <= m2l;
        s_msg2_high <= m2h;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Random item, weighted toward updates and reads so the state evolves and is seen.
    task automatic send_random(input bit gaps);
        int pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 35) kind = KIND_UPDATE;
        else if (pick < 55) kind = KIND_WRITE;
        else if (pick < 95) kind = KIND_READ;
        else kind = KIND_NONE;
        send_item(kind, 2'($urandom()), 3'($urandom()), 1'($urandom()), rand64(),
                  rand64(), rand64(), rand64(), rand64(), gaps);
    endtask

    initial begin
        logic [63:0] ones;
        ones = '1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reads of the zero state, extreme writes, update of a
        // written lane, the unused kind, and ignored fields.
        send_item(KIND_READ, 2'd0, 3'd0, 1'b0, ones, ones, ones, ones, ones, 0);
        send_item(KIND_READ, 2'd3, 3'd7, 1'b1, '0, '0, '0, '0, '0, 0);
        send_item(KIND_WRITE, 2'd3, 3'd7, 1'b1, ones, '0, '0, '0, '0, 0);
        send_item(KIND_WRITE, 2'd0, 3'd0, 1'b0, 64'h0123456789abcdef, ones, ones,
                  ones, ones, 0);
        send_item(KIND_READ, 2'd3, 3'd7, 1'b1, '0, '0, '0, '0, '0, 0);
        send_item(KIND_READ, 2'd0, 3'd0, 1'b0, '0, '0, '0, '0, '0, 0);
        send_item(KIND_UPDATE, 2'd0, 3'd0, 1'b0, '0, '0, '0, '0, '0, 0);
        send_item(KIND_UPDATE, 2'd3, 3'd5, 1'b1, ones, ones, ones, ones, ones, 0);
        send_item(KIND_NONE, 2'd0, 3'd0, 1'b0, ones, ones, ones, ones, ones, 0);
        for (int b = 0; b < 8; b++)
            send_item(KIND_READ, 2'd0, 3'(b), 1'(b), '0, '0, '0, '0, '0, 0);
        send_item(KIND_READ, 2'd3, 3'd0, 1'b0, '0, '0, '0, '0, '0, 0);
        send_item(KIND_READ, 2'd3, 3'd4, 1'b1, '0, '0, '0, '0, '0, 0);
        send_item(KIND_UPDATE, 2'd1, 3'd0, 1'b0, '0, 64'h1, 64'h0, 64'h0, ones, 0);
        send_item(KIND_READ, 2'd1, 3'd0, 1'b0, '0, '0, '0, '0, '0, 0);
        send_item(KIND_READ, 2'd1, 3'd4, 1'b1, '0, '0, '0, '0, '0, 0);

        // Random phases with gaps.
        for (int n = 0; n < 900; n++) send_random(1);
        s_valid <= 1'b0;
        // Let the checker count the last accepted item.
        @(posedge aclk);

        // Sender holds off until the result channel has drained.
        while (pending_reads != 0) @(posedge aclk);

        // Back-to-back stretch with no stalls on either side.
        stall_free = 1'b1;
        for (int n = 0; n < 200; n++) send_random(0);
        stall_free = 1'b0;
        for (int n = 0; n < 900; n++) send_random(1);
        s_valid <= 1'b0;
        @(posedge aclk);

        while (pending_reads != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/asu_pkg.sv
rtl/asu_front.sv
rtl/asu_back.sv
rtl/aegis_state_update_top.sv
tb/aegis_state_update_checker.sv
tb/aegis_state_update_top_tb.sv
